// File: rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// shared widths and pipeline types for the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int CW  = 16;             // vertex coordinate width
  localparam int FB  = 14;             // fraction bits of the normal
  localparam int OW  = 16;             // normal component width
  localparam int EW  = CW + 1;         // edge width
  localparam int PW  = 2 * EW;         // edge product width
  localparam int XW  = PW + 1;         // cross component width, signed
  localparam int MW  = XW - 1;         // cross component magnitude width
  localparam int QW  = 2 * MW;         // square width
  localparam int SW  = QW + 2;         // sum of three squares
  localparam int TW  = SW + FB + 1;    // running q * sum
  localparam int DW  = SW + 2 * FB + 2; // residual width
  localparam int KW  = $clog2(FB + 1); // bit index width
  localparam int NF  = 5;              // front stages
  localparam int NS  = NF + FB + 2;    // all stages incl. output register

  typedef struct packed {
    logic          neg;
    logic [DW-1:0] res;
    logic [TW-1:0] t;
    logic [FB:0]   q;
  } lane_t;

  typedef struct packed {
    logic          zero;
    logic [SW-1:0] s;
    lane_t [2:0]   lane;
  } cell_data_t;

endpackage

// File: rtl/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// edges, cross product, squares and squared length, five register stages
// ----------------------------------------------------------------------------
module tun_front (
  input  logic                            clk,
  input  logic [tun_pkg::NF-1:0]          en,
  input  logic signed [tun_pkg::CW-1:0]   p0 [3],
  input  logic signed [tun_pkg::CW-1:0]   p1 [3],
  input  logic signed [tun_pkg::CW-1:0]   p2 [3],
  output tun_pkg::cell_data_t             dout
);

  logic signed [tun_pkg::EW-1:0] a_r [3];
  logic signed [tun_pkg::EW-1:0] b_r [3];
  logic signed [tun_pkg::PW-1:0] pr_r [6];
  logic                          neg3_r [3];
  logic [tun_pkg::MW-1:0]        mag3_r [3];
  logic                          neg4_r [3];
  logic [tun_pkg::QW-1:0]        sq4_r [3];
  tun_pkg::cell_data_t           d5_r;
  logic signed [tun_pkg::XW-1:0] cr [3];
  tun_pkg::cell_data_t           d5_nxt;
  logic [tun_pkg::SW-1:0]        sum;

  always_comb begin
    cr[0] = tun_pkg::XW'(pr_r[0]) - tun_pkg::XW'(pr_r[1]);
    cr[1] = tun_pkg::XW'(pr_r[2]) - tun_pkg::XW'(pr_r[3]);
    cr[2] = tun_pkg::XW'(pr_r[4]) - tun_pkg::XW'(pr_r[5]);
    sum = tun_pkg::SW'(sq4_r[0]) + tun_pkg::SW'(sq4_r[1]) + tun_pkg::SW'(sq4_r[2]);
    d5_nxt.zero = (sum == '0);
    d5_nxt.s    = sum;
    for (int i = 0; i < 3; i++) begin
      d5_nxt.lane[i].neg = neg4_r[i];
      d5_nxt.lane[i].res = tun_pkg::DW'(sq4_r[i]) << (2 * tun_pkg::FB);
      d5_nxt.lane[i].t   = '0;
      d5_nxt.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= tun_pkg::EW'(p0[i]) - tun_pkg::EW'(p1[i]);
        b_r[i] <= tun_pkg::EW'(p1[i]) - tun_pkg::EW'(p2[i]);
      end
    end
    if (en[1]) begin
      pr_r[0] <= a_r[1] * b_r[2];
      pr_r[1] <= a_r[2] * b_r[1];
      pr_r[2] <= a_r[2] * b_r[0];
      pr_r[3] <= a_r[0] * b_r[2];
      pr_r[4] <= a_r[0] * b_r[1];
      pr_r[5] <= a_r[1] * b_r[0];
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= cr[i][tun_pkg::XW-1];
        mag3_r[i] <= tun_pkg::MW'(cr[i][tun_pkg::XW-1] ? -cr[i] : cr[i]);
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        neg4_r[i] <= neg3_r[i];
        sq4_r[i]  <= mag3_r[i] * mag3_r[i];
      end
    end
    if (en[4]) begin
      d5_r <= d5_nxt;
    end
  end

  assign dout = d5_r;

endmodule

// File: rtl/tun_cell.sv
// ----------------------------------------------------------------------------
// tun_cell
// one quotient bit of all three components by shift, add and compare
// ----------------------------------------------------------------------------
module tun_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tun_pkg::KW-1:0]    bit_idx,
  input  tun_pkg::cell_data_t       din,
  output tun_pkg::cell_data_t       dout
);

  tun_pkg::cell_data_t dout_r;
  tun_pkg::cell_data_t dout_nxt;
  logic [tun_pkg::DW-1:0] dec;
  logic [tun_pkg::DW-1:0] s_ext;

  // trying q + 2^k costs (2^(k+1) * q + 2^(2k)) * s, with q * s kept as t
  always_comb begin
    dout_nxt = din;
    s_ext    = tun_pkg::DW'(din.s);
    dec      = '0;
    for (int i = 0; i < 3; i++) begin
      dec = (tun_pkg::DW'(din.lane[i].t) << (bit_idx + 1'b1)) + (s_ext << (2 * bit_idx));
      if (din.lane[i].res >= dec) begin
        dout_nxt.lane[i].res = din.lane[i].res - dec;
        dout_nxt.lane[i].t   = din.lane[i].t + (tun_pkg::TW'(din.s) << bit_idx);
        dout_nxt.lane[i].q   = din.lane[i].q | ((tun_pkg::FB+1)'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// File: rtl/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// unit surface normal of a triangle, signed Q8.8 vertices to signed Q1.14
// ----------------------------------------------------------------------------
// channel | ports      | beat contents
// --------+------------+--------------------------------------------------
// input   | in_t*      | three vertices, nine 16-bit signed Q8.8 coords
// output  | out_t*     | normal x, y, z, three 16-bit signed Q1.14 values
//
// one beat per cycle sustained while out_tready is high; five front stages
// (edges, products, cross, squares, length), a chain of 15 cells each
// settling one quotient bit, and the output register
// every stage holds its own valid bit and refills while a later stage stalls
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0]  out_tdata
);

  logic [tun_pkg::NS-1:0]        v_r;
  logic [tun_pkg::NS-1:0]        en;
  logic signed [tun_pkg::CW-1:0] p0 [3];
  logic signed [tun_pkg::CW-1:0] p1 [3];
  logic signed [tun_pkg::CW-1:0] p2 [3];
  tun_pkg::cell_data_t           chain [tun_pkg::FB+2];
  logic [3*tun_pkg::OW-1:0]      out_r;
  logic [3*tun_pkg::OW-1:0]      out_nxt;
  logic signed [31:0]            val;

  // unpack the vertex coordinates, p0_x in the lowest bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = in_tdata[i*tun_pkg::CW +: tun_pkg::CW];
      p1[i] = in_tdata[(3+i)*tun_pkg::CW +: tun_pkg::CW];
      p2[i] = in_tdata[(6+i)*tun_pkg::CW +: tun_pkg::CW];
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[tun_pkg::NS-1] = !v_r[tun_pkg::NS-1] || out_tready;
    for (int i = tun_pkg::NS-2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < tun_pkg::NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  tun_front u_front (
    .clk  (clk),
    .en   (en[tun_pkg::NF-1:0]),
    .p0   (p0),
    .p1   (p1),
    .p2   (p2),
    .dout (chain[0])
  );

  // cell g settles quotient bit FB-g
  for (genvar g = 0; g <= tun_pkg::FB; g++) begin : g_cell
    tun_cell u_cell (
      .clk     (clk),
      .en      (en[tun_pkg::NF+g]),
      .bit_idx (tun_pkg::KW'(tun_pkg::FB - g)),
      .din     (chain[g]),
      .dout    (chain[g+1])
    );
  end

  // sign, saturation and the degenerate case
  always_comb begin
    out_nxt = '0;
    val     = '0;
    for (int i = 0; i < 3; i++) begin
      val = 32'(chain[tun_pkg::FB+1].lane[i].q);
      if (chain[tun_pkg::FB+1].lane[i].neg) begin
        val = -val;
        if (val < -32'sd32768) val = -32'sd32768;
      end else if (val > 32'sd32767) begin
        val = 32'sd32767;
      end
      if (chain[tun_pkg::FB+1].zero) val = '0;
      out_nxt[i*tun_pkg::OW +: tun_pkg::OW] = val[tun_pkg::OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[tun_pkg::NS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v_r[tun_pkg::NS-1];
  assign out_tdata  = out_r;

endmodule
